// ===== hdl/ita_pkg.sv =====
`default_nettype none
package ita_pkg;

   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned LEN_W = 5;
   localparam int unsigned DEC_W = 32;
   localparam int unsigned BCD_W = 40;
   localparam int unsigned NIB_W = 4;
   localparam int unsigned NUM_NIBS = VALUE_W / NIB_W;
   localparam int unsigned NIB_IDX_W = $clog2(NUM_NIBS);

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

   localparam logic [OPCODE_W-1:0] OP_SDEC = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_UDEC = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_HEXL = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_HEXU = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_PTR  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_MINUS,
      PFX_0X
   } pfx_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic [LEN_W-1:0]  total_length;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] digits;
      logic [LEN_W-1:0]   ndig;
      logic [LEN_W-1:0]   total;
      pfx_type            prefix;
      logic               upper;
   } entry_type;

endpackage
`default_nettype wire

// ===== hdl/ita_front.sv =====
`default_nettype none
module ita_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ita_pkg::req_type   req_data,
   output logic                    q_push,
   output ita_pkg::entry_type      q_push_data,
   input  wire logic               q_full
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } state_type;

   localparam int unsigned NUM_BCD = ita_pkg::BCD_W / ita_pkg::NIB_W;
   localparam int unsigned DD_W = ita_pkg::BCD_W + ita_pkg::DEC_W;
   localparam int unsigned STEP_W = $clog2(ita_pkg::DEC_W / 2);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ita_pkg::DEC_W / 2 - 1);

   state_type                        state_ff, state_in;
   logic [ita_pkg::VALUE_W-1:0]      val_ff, val_in;
   logic [ita_pkg::BCD_W-1:0]        bcd_ff, bcd_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   ita_pkg::pfx_type                 pfx_ff, pfx_in;
   logic                             upper_ff, upper_in;
   logic                             dec_ff, dec_in;

   logic [DD_W-1:0]                  dd_next;
   logic [ita_pkg::VALUE_W-1:0]      digits;
   logic [ita_pkg::LEN_W-1:0]        ndig;
   logic [ita_pkg::LEN_W-1:0]        plen;
   logic [ita_pkg::DEC_W-1:0]        low;

   // one shift-and-add-3 step of binary to bcd
   function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
      logic [DD_W-1:0] y;
      y = x;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (y[ita_pkg::DEC_W + ita_pkg::NIB_W*i +: ita_pkg::NIB_W] >= 4'd5) begin
            y[ita_pkg::DEC_W + ita_pkg::NIB_W*i +: ita_pkg::NIB_W] =
               y[ita_pkg::DEC_W + ita_pkg::NIB_W*i +: ita_pkg::NIB_W] + 4'd3;
         end
      end
      return {y[DD_W-2:0], 1'b0};
   endfunction

   assign req_ready = (state_ff == F_IDLE);
   assign low = req_data.value[ita_pkg::DEC_W-1:0];
   assign dd_next = dd_step(dd_step({bcd_ff, val_ff[ita_pkg::DEC_W-1:0]}));
   assign digits = dec_ff ? {{(ita_pkg::VALUE_W-ita_pkg::BCD_W){1'b0}}, bcd_ff} : val_ff;

   always_comb begin
      ndig = ita_pkg::LEN_W'(1);
      for (int n = 0; n < ita_pkg::NUM_NIBS; n++) begin
         if (digits[ita_pkg::NIB_W*n +: ita_pkg::NIB_W] != '0) begin
            ndig = ita_pkg::LEN_W'(n + 1);
         end
      end
   end

   always_comb begin
      case (pfx_ff)
         ita_pkg::PFX_MINUS: plen = ita_pkg::LEN_W'(1);
         ita_pkg::PFX_0X:    plen = ita_pkg::LEN_W'(2);
         default:            plen = '0;
      endcase
   end

   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_push_data.digits = digits;
   assign q_push_data.ndig = ndig;
   assign q_push_data.total = ndig + plen;
   assign q_push_data.prefix = pfx_ff;
   assign q_push_data.upper = upper_ff;

   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      bcd_in = bcd_ff;
      step_in = step_ff;
      pfx_in = pfx_ff;
      upper_in = upper_ff;
      dec_in = dec_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               step_in = '0;
               bcd_in = '0;
               upper_in = 1'b0;
               pfx_in = ita_pkg::PFX_NONE;
               val_in = req_data.value;
               case (req_data.opcode)
                  ita_pkg::OP_SDEC: begin
                     dec_in = 1'b1;
                     if (low[ita_pkg::DEC_W-1]) begin
                        pfx_in = ita_pkg::PFX_MINUS;
                        val_in = {{(ita_pkg::VALUE_W-ita_pkg::DEC_W){1'b0}}, ~low + 32'd1};
                     end
                     state_in = F_CONV;
                  end
                  ita_pkg::OP_UDEC: begin
                     dec_in = 1'b1;
                     state_in = F_CONV;
                  end
                  ita_pkg::OP_HEXL: begin
                     dec_in = 1'b0;
                     state_in = F_PUSH;
                  end
                  ita_pkg::OP_HEXU: begin
                     dec_in = 1'b0;
                     upper_in = 1'b1;
                     state_in = F_PUSH;
                  end
                  ita_pkg::OP_PTR: begin
                     dec_in = 1'b0;
                     pfx_in = ita_pkg::PFX_0X;
                     state_in = F_PUSH;
                  end
                  default: begin
                     state_in = F_IDLE;
                  end
               endcase
            end
         end
         F_CONV: begin
            bcd_in = dd_next[DD_W-1:ita_pkg::DEC_W];
            val_in = {{(ita_pkg::VALUE_W-ita_pkg::DEC_W){1'b0}},
                      dd_next[ita_pkg::DEC_W-1:0]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff <= val_in;
      bcd_ff <= bcd_in;
      step_ff <= step_in;
      pfx_ff <= pfx_in;
      upper_ff <= upper_in;
      dec_ff <= dec_in;
   end

endmodule
`default_nettype wire

// ===== hdl/ita_queue.sv =====
`default_nettype none
module ita_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ita_pkg::entry_type  push_data,
   output logic                     full,
   input  wire logic                pop,
   output ita_pkg::entry_type       pop_data,
   output logic                     empty
);

   ita_pkg::entry_type              mem_ff [ita_pkg::Q_DEPTH];
   logic [ita_pkg::Q_PTR_W-1:0]     wr_ff, wr_in;
   logic [ita_pkg::Q_PTR_W-1:0]     rd_ff, rd_in;
   logic [ita_pkg::Q_CNT_W-1:0]     cnt_ff, cnt_in;

   assign full = (cnt_ff == ita_pkg::Q_CNT_W'(ita_pkg::Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == ita_pkg::Q_PTR_W'(ita_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ff + ita_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == ita_pkg::Q_PTR_W'(ita_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ff + ita_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + ita_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - ita_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ita_back.sv =====
`default_nettype none
module ita_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire ita_pkg::entry_type  q_pop_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ita_pkg::rsp_type         rsp_data
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_MINUS,
      B_ZERO,
      B_X,
      B_DIG
   } state_type;

   state_type                          state_ff, state_in;
   logic [ita_pkg::VALUE_W-1:0]        digits_ff, digits_in;
   logic [ita_pkg::NIB_IDX_W-1:0]      idx_ff, idx_in;
   logic                               upper_ff, upper_in;
   logic [ita_pkg::LEN_W-1:0]          total_ff, total_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ita_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                               advance;
   logic [ita_pkg::NIB_W-1:0]          nib;
   logic [ita_pkg::CHAR_W-1:0]         dig_char;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop = advance && (state_ff == B_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign nib = digits_ff[{idx_ff, 2'b00} +: ita_pkg::NIB_W];

   always_comb begin
      if (nib < 4'd10) begin
         dig_char = ita_pkg::CH_ZERO + {4'b0, nib};
      end else begin
         dig_char = (upper_ff ? ita_pkg::CH_A_UP : ita_pkg::CH_A_LO)
                    + {4'b0, nib} - 8'd10;
      end
   end

   always_comb begin
      state_in = state_ff;
      digits_in = digits_ff;
      idx_in = idx_ff;
      upper_in = upper_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         rsp_in.last = 1'b0;
         rsp_in.total_length = '0;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  digits_in = q_pop_data.digits;
                  idx_in = ita_pkg::NIB_IDX_W'(q_pop_data.ndig - ita_pkg::LEN_W'(1));
                  upper_in = q_pop_data.upper;
                  total_in = q_pop_data.total;
                  case (q_pop_data.prefix)
                     ita_pkg::PFX_MINUS: state_in = B_MINUS;
                     ita_pkg::PFX_0X:    state_in = B_ZERO;
                     default:            state_in = B_DIG;
                  endcase
               end
            end
            B_MINUS: begin
               rsp_valid_in = 1'b1;
               rsp_in.character = ita_pkg::CH_MINUS;
               state_in = B_DIG;
            end
            B_ZERO: begin
               rsp_valid_in = 1'b1;
               rsp_in.character = ita_pkg::CH_ZERO;
               state_in = B_X;
            end
            B_X: begin
               rsp_valid_in = 1'b1;
               rsp_in.character = ita_pkg::CH_X;
               state_in = B_DIG;
            end
            B_DIG: begin
               rsp_valid_in = 1'b1;
               rsp_in.character = dig_char;
               if (idx_ff == '0) begin
                  rsp_in.last = 1'b1;
                  rsp_in.total_length = total_ff;
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff - ita_pkg::NIB_IDX_W'(1);
               end
            end
            default: begin
               state_in = B_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff <= digits_in;
      idx_ff <= idx_in;
      upper_ff <= upper_in;
      total_ff <= total_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// hex and pointer numbers go from the front straight into the queue; decimal numbers
// first pass through the bcd conversion, two bits a cycle
// throughput: one character per cycle within a number while rsp_ready is high; the front
// can take and convert the next number while the character emitter sends out earlier ones
// reset: synchronous, active high; clears the front, the 2-entry queue and the output stage
`default_nettype none
module integer_to_ascii_formatter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ita_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ita_pkg::rsp_type       rsp_data
);

   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;
   ita_pkg::entry_type   q_push_data;
   ita_pkg::entry_type   q_pop_data;

   ita_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_full      (q_full)
   );

   ita_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   ita_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop_data (q_pop_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue read while empty");

   a_last_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.total_length != '0))
      else $error("last transaction without length");

   a_mid_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.total_length == '0))
      else $error("length on a non-final transaction");

   a_dec_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.opcode == ita_pkg::OP_SDEC ||
       req_data.opcode == ita_pkg::OP_UDEC)) |=> !req_ready)
      else $error("front accepted during conversion");

endmodule
`default_nettype wire
